### src/hbs3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hbs3_pkg: shared types and constants of the 3x3 height smoothing filter
// Field widths, configuration register codes and the divisor lookup that
// turns a neighbour count into a rounding offset and a reciprocal.
// ----------------------------------------------------------------------------
package hbs3_pkg;

  localparam int unsigned MaxCols    = 1024;
  localparam int unsigned HeightBits = 16;
  localparam int unsigned ColsCfgW   = 11;
  localparam int unsigned RowsCfgW   = 13;
  localparam int unsigned CfgDataW   = 13;
  localparam int unsigned RowLimit   = 4096;
  localparam int unsigned RowLastW   = 12;
  localparam int unsigned InRowW     = 13;
  localparam int unsigned SumW       = 20;
  localparam int unsigned RecipW     = 25;
  localparam int unsigned RecipShift = 24;
  localparam int unsigned HalfW      = 3;

  typedef enum logic [0:0] {
    RegGridCols = 1'b0,
    RegGridRows = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic at_top;
    logic at_bottom;
    logic at_left;
    logic at_right;
    logic last;
  } border_t;

  typedef struct packed {
    logic [RecipW-1:0] recip;
    logic [HalfW-1:0]  half;
  } divisor_t;

  // recip = ceil(2^24 / count); exact for sums below 2^20
  function automatic divisor_t divisor_lookup(input logic [1:0] rows, input logic [1:0] cols);
    divisor_t   d;
    logic [3:0] cnt;
    cnt = {2'b00, rows} * {2'b00, cols};
    case (cnt)
      4'd2:    begin d.recip = 25'd8388608; d.half = 3'd1; end
      4'd3:    begin d.recip = 25'd5592406; d.half = 3'd1; end
      4'd4:    begin d.recip = 25'd4194304; d.half = 3'd2; end
      4'd6:    begin d.recip = 25'd2796203; d.half = 3'd3; end
      4'd9:    begin d.recip = 25'd1864136; d.half = 3'd4; end
      default: begin d.recip = 25'd16777216; d.half = 3'd0; end
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

### src/heightmap_box_smooth_3x3_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_box_smooth_3x3_top: edge-normalized 3x3 box filter on a height grid
// Line store, 3x3 window, masked sum and reciprocal divide in a short pipeline.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle, sample or drain, for as long as the output
// side keeps up. The result for raster position p is produced by the item
// that pushes position p+grid_cols+1 and leaves on m_axis after passing
// through the window, sum and reciprocal multiply stages. Both
// line stores share one MAX_COLS x 32-bit memory with one write and one
// registered read per cycle; the read address runs one column ahead of the
// push position. Drain items are taken but ignored until all samples of the
// grid have arrived; a sample arriving after that acts as a drain.
// A configuration write is always accepted and restarts the grid; issue it
// only while no item is in flight.
module heightmap_box_smooth_3x3_top #(
  parameter int unsigned MAX_COLS = hbs3_pkg::MaxCols
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  input  wire logic [hbs3_pkg::HeightBits-1:0]    s_axis_tdata_i,   // sample_height
  input  wire logic                               s_axis_tuser_i,   // func
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  output logic [hbs3_pkg::HeightBits-1:0]         m_axis_tdata_o,   // smoothed_height
  output logic                                    m_axis_tlast_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire hbs3_pkg::cfg_reg_e                 cfg_addr_i,
  input  wire logic [hbs3_pkg::CfgDataW-1:0]      cfg_data_i
);

  localparam int unsigned AddrW = $clog2(MAX_COLS);
  localparam int unsigned HB    = hbs3_pkg::HeightBits;
  localparam int unsigned LineW = 2 * HB;
  localparam int unsigned ProdW = hbs3_pkg::SumW + hbs3_pkg::RecipW;

  logic [hbs3_pkg::ColsCfgW-1:0] cfg_cols_q;
  logic [hbs3_pkg::RowsCfgW-1:0] cfg_rows_q;
  logic [AddrW-1:0]              cols_last;
  logic [hbs3_pkg::RowLastW-1:0] rows_last;

  logic [AddrW-1:0]              in_col_q, in_col_d;
  logic [hbs3_pkg::InRowW-1:0]   in_row_q, in_row_d;
  logic [AddrW-1:0]              out_col_q, out_col_d;
  logic [hbs3_pkg::RowLastW-1:0] out_row_q, out_row_d;

  logic cfg_wr, accept, full, push, emit;
  logic v1_q, v2_q, v3_q, rdy2, rdy3;

  logic [LineW-1:0] line_mem [MAX_COLS];
  logic [LineW-1:0] line_rd_q, fwd_data_q, line_pf;
  logic             fwd_q;
  logic [HB-1:0]    x, up, mid;

  logic [HB-1:0]           win_q [3][3];
  hbs3_pkg::border_t       border_d, border_q;
  logic [hbs3_pkg::SumW-1:0] sum, sum_q;
  hbs3_pkg::divisor_t      div, div_q;
  logic [1:0]              rows_n, cols_n;
  logic                    last2_q;
  logic [ProdW-1:0]        prod;
  logic [HB-1:0]           out_data_q;
  logic                    out_last_q;

  // configuration
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cols_q <= hbs3_pkg::ColsCfgW'(1024);
      cfg_rows_q <= hbs3_pkg::RowsCfgW'(1024);
    end else if (cfg_wr) begin
      unique case (cfg_addr_i)
        hbs3_pkg::RegGridCols: cfg_cols_q <= cfg_data_i[hbs3_pkg::ColsCfgW-1:0];
        hbs3_pkg::RegGridRows: cfg_rows_q <= cfg_data_i[hbs3_pkg::RowsCfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_cols_q == '0) begin
      cols_last = '0;
    end else if (32'(cfg_cols_q) > 32'(MAX_COLS)) begin
      cols_last = AddrW'(MAX_COLS - 1);
    end else begin
      cols_last = AddrW'(cfg_cols_q - 1'b1);
    end
    if (cfg_rows_q == '0) begin
      rows_last = '0;
    end else if (cfg_rows_q > hbs3_pkg::RowsCfgW'(hbs3_pkg::RowLimit)) begin
      rows_last = hbs3_pkg::RowLastW'(hbs3_pkg::RowLimit - 1);
    end else begin
      rows_last = hbs3_pkg::RowLastW'(cfg_rows_q - 1'b1);
    end
  end

  // handshake chain
  assign rdy3            = !v3_q || m_axis_tready_i;
  assign rdy2            = !v2_q || rdy3;
  assign s_axis_tready_o = !v1_q || rdy2;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign full = in_row_q > hbs3_pkg::InRowW'(rows_last);
  assign push = accept && (!s_axis_tuser_i || full);
  assign emit = push && ((in_row_q >= hbs3_pkg::InRowW'(2)) ||
                         (in_row_q == hbs3_pkg::InRowW'(1) && in_col_q != '0));
  assign x    = full ? '0 : s_axis_tdata_i;

  assign border_d.at_top    = out_row_q == '0;
  assign border_d.at_bottom = out_row_q == rows_last;
  assign border_d.at_left   = out_col_q == '0;
  assign border_d.at_right  = out_col_q == cols_last;
  assign border_d.last      = border_d.at_bottom && border_d.at_right;

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (push) begin
      if (in_col_q == cols_last) begin
        in_col_d = '0;
        in_row_d = in_row_q + 1'b1;
      end else begin
        in_col_d = in_col_q + 1'b1;
      end
    end
    if (emit) begin
      if (border_d.at_right) begin
        out_col_d = '0;
        out_row_d = out_row_q + 1'b1;
      end else begin
        out_col_d = out_col_q + 1'b1;
      end
    end
    if (cfg_wr || (emit && border_d.last)) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // line store: {upper, middle}, read one column ahead
  always_ff @(posedge clk_i) begin
    if (push) begin
      line_mem[in_col_q] <= {mid, x};
    end
    line_rd_q <= line_mem[in_col_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= push && (in_col_d == in_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= {mid, x};
  end

  assign line_pf = fwd_q ? fwd_data_q : line_rd_q;
  assign up      = line_pf[LineW-1:HB];
  assign mid     = line_pf[HB-1:0];

  // window stage
  always_ff @(posedge clk_i) begin
    if (push) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= up;
      win_q[1][2] <= mid;
      win_q[2][2] <= x;
      border_q    <= border_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (push) begin
        v1_q <= emit;
      end else if (rdy2) begin
        v1_q <= 1'b0;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // sum stage
  always_comb begin
    sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!((r == 0 && border_q.at_top) || (r == 2 && border_q.at_bottom) ||
              (c == 0 && border_q.at_left) || (c == 2 && border_q.at_right))) begin
          sum = sum + hbs3_pkg::SumW'(win_q[r][c]);
        end
      end
    end
  end

  assign rows_n = 2'd3 - {1'b0, border_q.at_top} - {1'b0, border_q.at_bottom};
  assign cols_n = 2'd3 - {1'b0, border_q.at_left} - {1'b0, border_q.at_right};
  assign div    = hbs3_pkg::divisor_lookup(rows_n, cols_n);

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      sum_q   <= sum + hbs3_pkg::SumW'(div.half);
      div_q   <= div;
      last2_q <= border_q.last;
    end
  end

  // reciprocal multiply into the result register
  assign prod = ProdW'(sum_q) * ProdW'(div_q.recip);

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      out_data_q <= prod[hbs3_pkg::RecipShift +: HB];
      out_last_q <= last2_q;
    end
  end

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef ASSERT_OFF
  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (v1_q && v2_q && v3_q))
    else $error("input stalled with a pipeline stage empty");

  a_in_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_col_q <= cols_last)
    else $error("push column beyond grid width");

  a_out_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_row_q <= rows_last)
    else $error("result row beyond grid height");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && border_d.last) |=> (in_col_q == '0 && in_row_q == '0 && out_col_q == '0))
    else $error("grid not restarted after its final result");
`endif

endmodule
`default_nettype wire

### sim/tb_heightmap_box_smooth_3x3_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heightmap_box_smooth_3x3_top: self-checking bench of the 3x3 height smoother
// Streams height grids of many sizes through the filter, predicts each rounded,
// edge-normalized neighbourhood mean and the end-of-grid mark, and compares
// every output item in order. Covers directed corner cases, zero-valued
// registers, single-register writes and a long output stall.
// ----------------------------------------------------------------------------
module tb_heightmap_box_smooth_3x3_top;

  localparam int unsigned CycleLimit = 800000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned LongHold = 2000;
  localparam int unsigned RandomSamples = 450;

  typedef enum logic {
    FuncSample = 1'b0,
    FuncDrain  = 1'b1
  } func_e;

  typedef enum int {
    PatUniform,
    PatExtreme,
    PatLow,
    PatRamp
  } height_pat_e;

  typedef enum int {
    RxOpen,
    RxRandom,
    RxSparse
  } rx_mode_e;

  typedef struct packed {
    func_e                           func;
    logic [hbs3_pkg::HeightBits-1:0] height;
  } raster_item_t;

  typedef struct packed {
    logic [hbs3_pkg::HeightBits-1:0] height;
    logic                            last;
  } smoothed_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_tvalid = 1'b0;
  logic                            s_axis_tready_o;
  logic [hbs3_pkg::HeightBits-1:0] s_tdata = '0;
  logic                            s_tuser = 1'b0;
  logic                            m_axis_tvalid_o;
  logic                            m_tready = 1'b0;
  logic [hbs3_pkg::HeightBits-1:0] m_axis_tdata_o;
  logic                            m_axis_tlast_o;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready_o;
  hbs3_pkg::cfg_reg_e              cfg_addr = hbs3_pkg::RegGridCols;
  logic [hbs3_pkg::CfgDataW-1:0]   cfg_data = '0;

  heightmap_box_smooth_3x3_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [hbs3_pkg::ColsCfgW-1:0]   grid_cols;
  logic [hbs3_pkg::RowsCfgW-1:0]   grid_rows;
  logic [hbs3_pkg::HeightBits-1:0] upper_line [hbs3_pkg::MaxCols];
  logic [hbs3_pkg::HeightBits-1:0] middle_line [hbs3_pkg::MaxCols];
  logic [hbs3_pkg::HeightBits-1:0] window [9];
  int unsigned                     push_row;
  int unsigned                     push_col;
  int unsigned                     smoothed_cnt;
  int unsigned                     center_row;
  int unsigned                     center_col;

  raster_item_t          raster_q[$];
  smoothed_t             smoothed_q[$];
  int unsigned           items_queued = 0;
  int unsigned           items_taken = 0;
  int unsigned           samples_sent = 0;
  int unsigned           err_cnt = 0;
  int unsigned           cycle_cnt = 0;
  int unsigned           hold_requests = 0;
  int unsigned           holds_done = 0;
  int unsigned           hold_left = 0;
  int unsigned           burst_left = 1;
  int unsigned           gap_left = 0;
  int unsigned           rx_left = 0;
  rx_mode_e              rx_mode = RxOpen;

  function automatic int unsigned active_cols();
    if (grid_cols == 0) return 1;
    if (grid_cols > hbs3_pkg::MaxCols) return hbs3_pkg::MaxCols;
    return grid_cols;
  endfunction

  function automatic int unsigned active_rows();
    if (grid_rows == 0) return 1;
    if (grid_rows > hbs3_pkg::RowLimit) return hbs3_pkg::RowLimit;
    return grid_rows;
  endfunction

  function automatic void restart_grid();
    push_row = 0;
    push_col = 0;
    smoothed_cnt = 0;
    center_row = 0;
    center_col = 0;
  endfunction

  task automatic smooth_push(input func_e fn,
                             input logic [hbs3_pkg::HeightBits-1:0] height);
    int unsigned                     w;
    int unsigned                     h;
    int unsigned                     total;
    int unsigned                     sum;
    int unsigned                     cnt;
    logic [hbs3_pkg::HeightBits-1:0] x;
    logic [hbs3_pkg::HeightBits-1:0] up;
    logic [hbs3_pkg::HeightBits-1:0] mid;
    logic                            grid_full;
    logic                            window_ready;
    smoothed_t                       res;
    w = active_cols();
    h = active_rows();
    total = w * h;
    grid_full = (push_row >= h);
    // drop drains that arrive before the grid is complete
    if (fn == FuncDrain && !grid_full) return;
    x = grid_full ? '0 : height;
    up = upper_line[push_col];
    mid = middle_line[push_col];
    upper_line[push_col] = mid;
    middle_line[push_col] = x;
    for (int r = 0; r < 3; r++) begin
      window[r*3] = window[r*3+1];
      window[r*3+1] = window[r*3+2];
    end
    window[2] = up;
    window[5] = mid;
    window[8] = x;
    window_ready = (push_row >= 2) || (push_row == 1 && push_col >= 1);
    push_col++;
    if (push_col >= w) begin
      push_col = 0;
      if (push_row < hbs3_pkg::RowLimit + 2) push_row++;
    end
    if (!window_ready || smoothed_cnt >= total) return;
    sum = 0;
    cnt = 0;
    for (int r = 0; r < 3; r++) begin
      if (!(r == 0 && center_row == 0) && !(r == 2 && center_row + 1 >= h)) begin
        for (int c = 0; c < 3; c++) begin
          if (!(c == 0 && center_col == 0) && !(c == 2 && center_col + 1 >= w)) begin
            sum += window[r*3+c];
            cnt++;
          end
        end
      end
    end
    res.height = hbs3_pkg::HeightBits'((sum + cnt / 2) / cnt);
    res.last = (smoothed_cnt + 1 == total);
    smoothed_q.push_back(res);
    smoothed_cnt++;
    center_col++;
    if (center_col >= w) begin
      center_col = 0;
      center_row++;
    end
    if (smoothed_cnt >= total) restart_grid();
  endtask

  task automatic queue_item(input func_e fn,
                            input logic [hbs3_pkg::HeightBits-1:0] height);
    raster_item_t it;
    it.func = fn;
    it.height = height;
    raster_q.push_back(it);
    items_queued++;
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || smoothed_q.size() != 0) @(posedge clk_i);
    // let items that give no result leave the pipeline
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input hbs3_pkg::cfg_reg_e idx, input int unsigned value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= hbs3_pkg::CfgDataW'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == hbs3_pkg::RegGridCols) grid_cols = hbs3_pkg::ColsCfgW'(value);
    else grid_rows = hbs3_pkg::RowsCfgW'(value);
    restart_grid();
  endtask

  task automatic set_grid(input int unsigned cols, input int unsigned rows, input int which);
    wait_idle();
    if (which == 1) begin
      write_reg(hbs3_pkg::RegGridCols, cols);
    end else if (which == 2) begin
      write_reg(hbs3_pkg::RegGridRows, rows);
    end else if ($urandom_range(0, 1) == 0) begin
      write_reg(hbs3_pkg::RegGridCols, cols);
      write_reg(hbs3_pkg::RegGridRows, rows);
    end else begin
      write_reg(hbs3_pkg::RegGridRows, rows);
      write_reg(hbs3_pkg::RegGridCols, cols);
    end
  endtask

  function automatic logic [hbs3_pkg::HeightBits-1:0] pick_height(input height_pat_e pat,
                                                                  input int unsigned idx);
    case (pat)
      PatExtreme: return ($urandom_range(0, 1) == 1) ? '1 : '0;
      PatLow:     return hbs3_pkg::HeightBits'($urandom_range(0, 7));
      PatRamp:    return hbs3_pkg::HeightBits'(idx * 97);
      default:    return hbs3_pkg::HeightBits'($urandom_range(0, 65535));
    endcase
  endfunction

  // keep: number of samples to send; a full grid gets its flushing items too
  task automatic send_grid(input height_pat_e pat, input int unsigned noise_pct,
                           input int unsigned keep);
    int unsigned w;
    int unsigned total;
    int unsigned n;
    w = active_cols();
    total = w * active_rows();
    n = (keep < total) ? keep : total;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < noise_pct) queue_item(FuncDrain, pick_height(PatUniform, i));
      queue_item(FuncSample, pick_height(pat, i));
    end
    samples_sent += n;
    if (n == total) begin
      for (int unsigned i = 0; i <= w; i++) begin
        if ($urandom_range(0, 1) == 1) queue_item(FuncDrain, pick_height(PatUniform, i));
        else queue_item(FuncSample, pick_height(PatUniform, i));
      end
    end
  endtask

  always @(posedge clk_i) begin : sample_driver
    logic         offer;
    raster_item_t it;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      offer = s_tvalid;
      if (s_tvalid && s_axis_tready_o) begin
        smooth_push(func_e'(s_tuser), s_tdata);
        items_taken++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (raster_q.size() > 0) begin
          it = raster_q.pop_front();
          s_tdata <= it.height;
          s_tuser <= it.func;
          offer = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      s_tvalid <= offer;
    end
  end

  always @(posedge clk_i) begin : result_monitor
    logic      rdy;
    smoothed_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_tready) begin
        if (smoothed_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, got height %h last %b",
                   $time, m_axis_tdata_o, m_axis_tlast_o);
          err_cnt++;
        end else begin
          want = smoothed_q.pop_front();
          if (m_axis_tdata_o !== want.height) begin
            $display("%0t: smoothed_height expected %h got %h",
                     $time, want.height, m_axis_tdata_o);
            err_cnt++;
          end
          if (m_axis_tlast_o !== want.last) begin
            $display("%0t: last_of_grid expected %b got %b",
                     $time, want.last, m_axis_tlast_o);
            err_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (hold_requests != holds_done) begin
        holds_done++;
        hold_left = LongHold;
        rdy = 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 2));
          rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
          RxOpen:   rdy = 1'b1;
          RxRandom: rdy = ($urandom_range(0, 1) == 1);
          default:  rdy = ($urandom_range(0, 3) == 0);
        endcase
      end
      m_tready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned cols;
    int unsigned rows;
    int unsigned sel;
    int unsigned grid_idx;
    int unsigned base;
    logic        must_cfg;
    grid_cols = hbs3_pkg::ColsCfgW'(1024);
    grid_rows = hbs3_pkg::RowsCfgW'(1024);
    for (int i = 0; i < hbs3_pkg::MaxCols; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 9; i++) window[i] = '0;
    restart_grid();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // 3x3 grid: corners, edges, center, mid-grid drain, sample used as drain
    set_grid(3, 3, 0);
    queue_item(FuncSample, 16'hFFFF);
    queue_item(FuncSample, 16'h0000);
    queue_item(FuncSample, 16'hFFFF);
    queue_item(FuncSample, 16'h0000);
    queue_item(FuncDrain, 16'h5A5A);
    queue_item(FuncSample, 16'hFFFF);
    queue_item(FuncSample, 16'h0000);
    queue_item(FuncSample, 16'hFFFF);
    queue_item(FuncSample, 16'hFFFF);
    queue_item(FuncSample, 16'h0001);
    queue_item(FuncDrain, 16'h0000);
    queue_item(FuncSample, 16'h1234);
    queue_item(FuncDrain, 16'hFFFF);
    queue_item(FuncDrain, 16'h0000);
    queue_item(FuncDrain, 16'h0000);
    // zero registers act as a 1x1 grid
    set_grid(0, 0, 0);
    queue_item(FuncSample, 16'h8001);
    queue_item(FuncDrain, 16'h0000);
    queue_item(FuncDrain, 16'h0000);
    // one-row grid flushed by drains
    set_grid(2, 1, 0);
    queue_item(FuncSample, 16'hFFFF);
    queue_item(FuncSample, 16'hFFFE);
    queue_item(FuncDrain, 16'h0000);
    queue_item(FuncDrain, 16'h0000);
    queue_item(FuncDrain, 16'h0000);

    // long output stall on a mid-size grid, then single-register writes
    set_grid(40, 6, 0);
    hold_requests++;
    send_grid(PatUniform, 1, '1);
    set_grid(0, 2, 2);
    set_grid(3, 0, 1);
    send_grid(PatRamp, 0, '1);

    base = samples_sent;
    grid_idx = 0;
    must_cfg = 1'b1;
    while (samples_sent - base < RandomSamples) begin
      if (must_cfg || $urandom_range(0, 9) < 7) begin
        sel = $urandom_range(0, 19);
        if (sel < 14) begin
          cols = $urandom_range(1, 8);
          rows = $urandom_range(1, 6);
        end else if (sel < 18) begin
          cols = $urandom_range(9, 40);
          rows = $urandom_range(1, 8);
        end else if (sel == 18) begin
          cols = 0;
          rows = $urandom_range(0, 5);
        end else begin
          cols = $urandom_range(1, 6);
          rows = 0;
        end
        if (grid_idx == 4) begin
          cols = 5;
          rows = 4;
        end
        set_grid(cols, rows, 0);
        must_cfg = 1'b0;
      end
      if (grid_idx == 4) begin
        // abandon a grid halfway, then restart through a register write
        send_grid(height_pat_e'($urandom_range(0, 3)), 5, 9);
        must_cfg = 1'b1;
      end else begin
        send_grid(height_pat_e'($urandom_range(0, 3)), $urandom_range(0, 8), '1);
        if ($urandom_range(0, 4) == 0) queue_item(FuncDrain, pick_height(PatUniform, 0));
      end
      grid_idx++;
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
